// File: src/vzs_pkg.sv
// Shared constants and types for the vector z-score normalizer.
package vzs_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SAMP_W  = 32;
  localparam int SUM_W   = SAMP_W + ADDR_W;
  localparam int SQ_W    = 2 * SAMP_W;
  localparam int ACC_W   = SQ_W + CNT_W;
  localparam int DVD_W   = ACC_W;
  localparam int DSR_W   = 32;
  localparam int STEP_W  = $clog2(DVD_W + 1);
  localparam int FRAC_W  = 16;
  localparam int ZQ_W    = SAMP_W + FRAC_W;
  localparam int ROOT_W  = SQ_W / 2;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: src/vzs_store.sv
// Sample memory: one write port and one registered read port.
module vzs_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [vzs_pkg::ADDR_W-1:0] wr_addr,
  input  logic [vzs_pkg::SAMP_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [vzs_pkg::ADDR_W-1:0] rd_addr,
  output logic [vzs_pkg::SAMP_W-1:0] rd_data
);
  import vzs_pkg::*;

  logic [SAMP_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/vzs_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module vzs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vzs_pkg::div_req_t         req,
  input  logic [vzs_pkg::DVD_W-1:0] dividend,
  input  logic [vzs_pkg::DSR_W-1:0] divisor,
  output vzs_pkg::unit_stat_t       stat,
  output logic [vzs_pkg::DVD_W-1:0] quotient
);
  import vzs_pkg::*;

  logic [DVD_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              ge;

  // The dividend's significant bits sit at its top; each step brings one in.
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// File: src/vzs_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module vzs_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vzs_pkg::SQ_W-1:0]   value,
  output vzs_pkg::unit_stat_t        stat,
  output logic [vzs_pkg::ROOT_W-1:0] root
);
  import vzs_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   v_r;
  logic [ROOT_W+2:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              ge;

  assign rem_sh = {rem_r[ROOT_W:0], v_r[SQ_W-1:SQ_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      v_r    <= {v_r[SQ_W-3:0], 2'b00};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

// File: src/vector_z_score_normalizer_top.sv
// Top level of the vector z-score normalizer: sequencer, statistics and output register.
//
// The block takes one vector of signed Q16.16 words (up to MAX_LEN = 64 of them,
// ended by tlast or by reaching MAX_LEN, the latter flagged cut short) into an
// on-chip sample memory, one word per cycle. After the final word it stops
// taking input, divides the running sum for the population mean and makes one
// pass over the memory for the standard deviation, then a second pass that emits
// one standardized word per sample, in arrival order. Each result comes from
// the 48-step serial divider that forms (x - mean) * 2^16 / sd. A flat
// vector (sd of zero) skips that divider. A single one-bit-per-cycle divider
// serves all three divisions. Input is taken again once the last result sits
// in the output register.
module vector_z_score_normalizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] z_value
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // [0] flat_vector, [1] saturated, [2] cut_short
);
  import vzs_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_MEANGO = 9'b000000010,
    S_MEAN   = 9'b000000100,
    S_SUMSQ  = 9'b000001000,
    S_VARDIV = 9'b000010000,
    S_SQRT   = 9'b000100000,
    S_RD     = 9'b001000000,
    S_CALC   = 9'b010000000,
    S_DIV    = 9'b100000000
  } state_t;

  // Result hand-off uses the divider-done path or the flat path, then the S_RD
  // logic below loads the output register; a pending result is held in res_z_r, flagged by res_v_r.
  state_t st_r, st_nxt;

  logic [CNT_W-1:0]         fill_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     cut_r;
  logic signed [SAMP_W:0]   mean_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ROOT_W-1:0]        sd_r;
  logic [CNT_W-1:0]         iss_r;
  logic                     rv_r, mv_r, sv_r;
  logic [SAMP_W-1:0]        m_r;
  logic [SQ_W-1:0]          sq_r;
  logic [CNT_W-1:0]         idx_r;
  logic                     neg_r;
  logic                     res_v_r;
  logic [SAMP_W-1:0]        res_z_r;
  logic                     res_sat_r;
  logic                     res_last_r;
  logic                     out_v_r;
  logic [SAMP_W-1:0]        out_z_r;
  logic                     out_last_r, out_flat_r, out_sat_r, out_cut_r;

  logic                     in_acc;
  logic                     load_end;
  logic [CNT_W-1:0]         fill_inc;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [SAMP_W-1:0]        rd_data;
  logic signed [SAMP_W+1:0] dev;
  logic [SAMP_W+1:0]        dev_mag;
  logic [SUM_W-1:0]         sum_mag;
  div_req_t                 div_req;
  logic [DVD_W-1:0]         div_dvd;
  logic [DSR_W-1:0]         div_dsr;
  unit_stat_t               div_stat;
  logic [DVD_W-1:0]         div_quo;
  logic                     sq_start;
  unit_stat_t               sq_stat;
  logic [ROOT_W-1:0]        sq_root;
  logic [ZQ_W-1:0]          zq;
  logic                     z_sat;
  logic [SAMP_W-1:0]        z_val;
  logic                     put_ok;
  logic                     pipe_idle;

  assign in_tready = (st_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign fill_inc  = fill_r + CNT_W'(1);
  assign load_end  = in_acc && (in_tlast || (fill_inc == CNT_W'(MAX_LEN)));

  // Deviation of the word just read from the mean; its magnitude is below 2^32.
  assign dev     = $signed({{2{rd_data[SAMP_W-1]}}, rd_data}) -
                   $signed({mean_r[SAMP_W], mean_r});
  assign dev_mag = dev[SAMP_W+1] ? (SAMP_W+2)'(-dev) : dev;
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[ADDR_W-1:0];
    if (st_r == S_SUMSQ) begin
      rd_en   = (iss_r != fill_r);
      rd_addr = iss_r[ADDR_W-1:0];
    end else if (st_r == S_RD) begin
      rd_en = 1'b1;
    end
  end

  vzs_store u_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pipe_idle = !rv_r && !mv_r && !sv_r && (iss_r == fill_r);

  // The single divider works for the mean, the variance and each result.
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(SUM_W);
    div_dvd       = {sum_mag, (DVD_W-SUM_W)'(0)};
    div_dsr       = DSR_W'(fill_r);
    case (st_r)
      S_MEANGO: begin
        div_req.start = 1'b1;
      end
      S_SUMSQ: begin
        div_req.start = pipe_idle;
        div_req.steps = STEP_W'(DVD_W);
        div_dvd       = acc_r;
      end
      S_CALC: begin
        div_req.start = (sd_r != '0);
        div_req.steps = STEP_W'(ZQ_W);
        div_dvd       = {dev_mag[SAMP_W-1:0], (DVD_W-SAMP_W)'(0)};
        div_dsr       = sd_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  vzs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign sq_start = (st_r == S_VARDIV) && div_stat.done;

  vzs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (div_quo[SQ_W-1:0]),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  // Truncated quotient, then clipped to the signed Q16.16 range.
  assign zq = div_quo[ZQ_W-1:0];
  always_comb begin
    if (neg_r) begin
      z_sat = zq > ZQ_W'(33'h080000000);
      z_val = z_sat ? 32'h80000000 : SAMP_W'(-zq);
    end else begin
      z_sat = zq > ZQ_W'(32'h7FFFFFFF);
      z_val = z_sat ? 32'h7FFFFFFF : zq[SAMP_W-1:0];
    end
  end

  assign put_ok = !out_v_r || out_tready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_LOAD:   if (load_end) st_nxt = S_MEANGO;
      S_MEANGO: st_nxt = S_MEAN;
      S_MEAN:   if (div_stat.done) st_nxt = S_SUMSQ;
      S_SUMSQ:  if (pipe_idle) st_nxt = S_VARDIV;
      S_VARDIV: if (div_stat.done) st_nxt = S_SQRT;
      S_SQRT:   if (sq_stat.done) st_nxt = S_RD;
      S_RD:     if (!res_v_r) st_nxt = S_CALC;
      S_CALC:   st_nxt = (sd_r == '0) ? S_RD : S_DIV;
      S_DIV:    if (div_stat.done) st_nxt = S_RD;
      default:  st_nxt = S_LOAD;
    endcase
    // After the final result is handed over, the block takes input again.
    if ((st_r == S_RD) && res_v_r && res_last_r && put_ok) begin
      st_nxt = S_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_LOAD;
      fill_r  <= '0;
      sum_r   <= '0;
      cut_r   <= 1'b0;
      iss_r   <= '0;
      rv_r    <= 1'b0;
      mv_r    <= 1'b0;
      sv_r    <= 1'b0;
      idx_r   <= '0;
      res_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        fill_r <= fill_inc;
        sum_r  <= sum_r + SUM_W'($signed(in_tdata));
        cut_r  <= !in_tlast && (fill_inc == CNT_W'(MAX_LEN));
      end
      if (st_r == S_MEANGO) begin
        iss_r <= '0;
        idx_r <= '0;
      end
      rv_r <= rd_en && (st_r == S_SUMSQ);
      mv_r <= rv_r;
      sv_r <= mv_r;
      if (rd_en && (st_r == S_SUMSQ)) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if ((st_r == S_RD) && res_v_r && put_ok) begin
        out_v_r <= 1'b1;
        res_v_r <= 1'b0;
        idx_r   <= idx_r + CNT_W'(1);
        if (res_last_r) begin
          fill_r <= '0;
          sum_r  <= '0;
          cut_r  <= 1'b0;
        end
      end
      if ((st_r == S_CALC) && (sd_r == '0)) begin
        res_v_r <= 1'b1;
      end
      if ((st_r == S_DIV) && div_stat.done) begin
        res_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == S_MEAN) && div_stat.done) begin
      mean_r <= sum_r[SUM_W-1] ? (SAMP_W+1)'(-div_quo[SAMP_W:0])
                               : $signed(div_quo[SAMP_W:0]);
    end
    if (st_r == S_MEANGO) begin
      acc_r <= '0;
    end else if (sv_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
    if (rv_r) begin
      m_r <= dev_mag[SAMP_W-1:0];
    end
    if (mv_r) begin
      sq_r <= m_r * m_r;
    end
    if (sq_stat.done) begin
      sd_r <= sq_root;
    end
    if (st_r == S_CALC) begin
      neg_r      <= dev[SAMP_W+1];
      res_last_r <= (idx_r + CNT_W'(1)) == fill_r;
      res_z_r    <= '0;
      res_sat_r  <= 1'b0;
    end
    if ((st_r == S_DIV) && div_stat.done) begin
      res_z_r   <= z_val;
      res_sat_r <= z_sat;
    end
    if ((st_r == S_RD) && res_v_r && put_ok) begin
      out_z_r    <= res_z_r;
      out_last_r <= res_last_r;
      out_flat_r <= (sd_r == '0);
      out_sat_r  <= res_sat_r;
      out_cut_r  <= cut_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_z_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_cut_r, out_sat_r, out_flat_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_LEN))
    else $error("sample count beyond the vector limit");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_flat_r) |-> (out_z_r == '0) && !out_sat_r)
    else $error("flat vector word is not zero");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_RD) && res_v_r && res_last_r && put_ok) |=>
      (fill_r == '0) && (st_r == S_LOAD))
    else $error("vector state not cleared after final word");

endmodule
